[rtl/url_percent_codec_macros.svh]
// Assertion macros for the URL percent codec.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef URL_PERCENT_CODEC_MACROS_SVH
`define URL_PERCENT_CODEC_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("upc assertion failed");

// next-cycle implication
`define UPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("upc assertion failed");

`else

`define UPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/upc_pkg.sv]
// Package for the URL percent codec: codes, result type and character classes.
// No dependencies; used by the top level.
package upc_pkg;

    // mode register values
    localparam logic [1:0] MODE_STRICT = 2'd0;
    localparam logic [1:0] MODE_PART   = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;
    localparam logic [1:0] MODE_CHECK  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ILLEGAL  = 2'd1;
    localparam logic [1:0] ST_BAD_HEX  = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    // register index of the mode register
    localparam logic REG_MODE = 1'b0;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [4:0] HEX_NONE   = 5'd16;
    localparam int unsigned RES_DEPTH = 3;

    // escape tracking
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
        logic [1:0] status;
    } t_result;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
               (b >= 8'h61 && b <= 8'h7a);
    endfunction

    // . , : / \ _ - ~ !
    function automatic logic in_strict(input logic [7:0] b);
        logic mark;
        case (b)
            8'h2e, 8'h2c, 8'h3a, 8'h2f, 8'h5c, 8'h5f, 8'h2d, 8'h7e, 8'h21: mark = 1'b1;
            default: mark = 1'b0;
        endcase
        return mark | is_alnum(b);
    endfunction

    // . , _ - !
    function automatic logic in_part(input logic [7:0] b);
        logic mark;
        case (b)
            8'h2e, 8'h2c, 8'h5f, 8'h2d, 8'h21: mark = 1'b1;
            default: mark = 1'b0;
        endcase
        return mark | is_alnum(b);
    endfunction

    // . , : / \ _ - @ & * + ~ ! ( ) [ ] '
    function automatic logic in_lax(input logic [7:0] b);
        logic mark;
        case (b)
            8'h2e, 8'h2c, 8'h3a, 8'h2f, 8'h5c, 8'h5f, 8'h2d, 8'h40, 8'h26,
            8'h2a, 8'h2b, 8'h7e, 8'h21, 8'h28, 8'h29, 8'h5b, 8'h5d, 8'h27: mark = 1'b1;
            default: mark = 1'b0;
        endcase
        return mark | is_alnum(b);
    endfunction

    // digit value, HEX_NONE when not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = b - 8'h37;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = b - 8'h57;
        end else begin
            v = {3'b000, HEX_NONE};
        end
        return v[4:0];
    endfunction

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
    endfunction

endpackage

[rtl/upc_in_if.sv]
// Input channel of the URL percent codec: one string byte per request.
// No dependencies.
interface upc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/upc_out_if.sv]
// Output channel of the URL percent codec: one result per request.
// No dependencies.
interface upc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic [1:0] status;

    modport source (output valid, output out_byte, output has_byte,
                    output end_of_string, output status, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input end_of_string, input status, output ready);
endinterface

[rtl/url_percent_codec.sv]
// URL percent codec top level: encode, decode and syntax check on a byte stream.
// Depends on upc_pkg, upc_in_if, upc_out_if and url_percent_codec_macros.svh.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  i_in     | in  | in_byte[7:0], in_last                      | valid/ready
//  o_out    | out | out_byte[7:0], has_byte, end_of_string,    | valid/ready
//           |     | status[1:0]                                |
//  APB      | in  | mode register at byte address 0            | psel/penable
//
// An accepted byte is processed in the cycle it is taken and its results are
// loaded into a three-entry result buffer that drains one result per cycle while
// the output is ready. A new byte is taken once the buffer holds at most one
// result being taken, so the three results of an escaped encode byte block input.
// Synchronous active-low reset clears the codec state, the mode and the buffer.
// A stalled output simply holds the buffer head and blocks the input.
`include "url_percent_codec_macros.svh"

module url_percent_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    upc_in_if.sink      i_in,
    upc_out_if.source   o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import upc_pkg::*;

    logic [1:0] r_mode;
    t_esc       r_phase, n_phase;
    logic [3:0] r_hinib, n_hinib;
    logic [1:0] r_err, n_err;
    t_result    r_res [RES_DEPTH];
    t_result    n_res [RES_DEPTH];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    logic       in_fire, out_fire;
    logic [7:0] b;
    logic [4:0] hv;
    logic       is_enc, is_check;
    logic       cfg_wr;

    // register port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite;
    assign o_prdata = (i_paddr[2] == REG_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STRICT;
        end else if (cfg_wr && i_paddr[2] == REG_MODE) begin
            r_mode <= i_pwdata[1:0];
        end
    end

    // handshakes
    assign out_fire   = o_out.valid & o_out.ready;
    assign i_in.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);
    assign in_fire    = i_in.valid & i_in.ready;

    assign b        = i_in.in_byte;
    assign hv       = hex_value(b);
    assign is_enc   = (r_mode == MODE_STRICT) || (r_mode == MODE_PART);
    assign is_check = (r_mode == MODE_CHECK);

    // next codec state
    always_comb begin
        n_phase = r_phase;
        n_hinib = r_hinib;
        n_err   = r_err;
        if (is_enc) begin
            n_phase = ESC_NONE;
        end else if (r_err == ST_OK) begin
            if (r_phase == ESC_NONE) begin
                if (is_check && in_lax(b)) begin
                    n_phase = ESC_NONE;
                end else if (b == CH_PERCENT) begin
                    n_phase = ESC_HIGH;
                end else if (is_check) begin
                    n_err = ST_ILLEGAL;
                end
            end else if (hv == HEX_NONE) begin
                n_err   = ST_BAD_HEX;
                n_phase = ESC_NONE;
            end else if (r_phase == ESC_HIGH) begin
                n_hinib = hv[3:0];
                n_phase = ESC_LOW;
            end else begin
                n_phase = ESC_NONE;
            end
        end
        // string end: flag an open escape, then back to idle
        if (i_in.in_last) begin
            if (n_err == ST_OK && n_phase != ESC_NONE) begin
                n_err = ST_TRUNC;
            end
        end
    end

    // results of the byte
    always_comb begin
        n_res = '{default: '0};
        n_cnt = 2'd0;
        if (is_enc) begin
            if (r_err == ST_OK) begin
                if ((r_mode == MODE_STRICT) ? in_strict(b) : in_part(b)) begin
                    n_res[0] = '{out_byte: b, has_byte: 1'b1,
                                 end_of_string: 1'b0, status: ST_OK};
                    n_cnt = 2'd1;
                end else begin
                    n_res[0] = '{out_byte: CH_PERCENT, has_byte: 1'b1,
                                 end_of_string: 1'b0, status: ST_OK};
                    n_res[1] = '{out_byte: hex_char(b[7:4]), has_byte: 1'b1,
                                 end_of_string: 1'b0, status: ST_OK};
                    n_res[2] = '{out_byte: hex_char(b[3:0]), has_byte: 1'b1,
                                 end_of_string: 1'b0, status: ST_OK};
                    n_cnt = 2'd3;
                end
            end
        end else if (r_err == ST_OK && !is_check) begin
            if (r_phase == ESC_NONE && b != CH_PERCENT) begin
                // decode passes plain bytes through
                n_res[0] = '{out_byte: b, has_byte: 1'b1,
                             end_of_string: 1'b0, status: ST_OK};
                n_cnt = 2'd1;
            end else if (r_phase == ESC_LOW && hv != HEX_NONE) begin
                n_res[0] = '{out_byte: {r_hinib, hv[3:0]}, has_byte: 1'b1,
                             end_of_string: 1'b0, status: ST_OK};
                n_cnt = 2'd1;
            end
        end
        // final status rides on the last result, or on a status-only result
        if (i_in.in_last) begin
            case (n_cnt)
                2'd0: begin
                    n_res[0] = '{out_byte: 8'h00, has_byte: 1'b0,
                                 end_of_string: 1'b1, status: n_err};
                    n_cnt = 2'd1;
                end
                2'd1: begin
                    n_res[0].end_of_string = 1'b1;
                    n_res[0].status        = n_err;
                end
                2'd3: begin
                    n_res[2].end_of_string = 1'b1;
                    n_res[2].status        = n_err;
                end
                default: begin
                    n_res[1].end_of_string = 1'b1;
                    n_res[1].status        = n_err;
                end
            endcase
        end
    end

    // codec state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_NONE;
            r_hinib <= 4'h0;
            r_err   <= ST_OK;
        end else if (in_fire) begin
            if (i_in.in_last) begin
                r_phase <= ESC_NONE;
                r_hinib <= 4'h0;
                r_err   <= ST_OK;
            end else begin
                r_phase <= n_phase;
                r_hinib <= n_hinib;
                r_err   <= n_err;
            end
        end
    end

    // result buffer: load on accept, shift on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_fire) begin
            r_cnt <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end else if (out_fire) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.out_byte      = r_res[0].out_byte;
    assign o_out.has_byte      = r_res[0].has_byte;
    assign o_out.end_of_string = r_res[0].end_of_string;
    assign o_out.status        = r_res[0].status;

    // checks
    `UPC_ASSERT_IMP(a_load_only_when_free, i_clk, i_rst_n, in_fire, (r_cnt == 2'd0) || (r_cnt == 2'd1 && out_fire))
    `UPC_ASSERT_IMP(a_eos_is_last_entry, i_clk, i_rst_n, o_out.valid && o_out.end_of_string, r_cnt == 2'd1)
    `UPC_ASSERT_IMP(a_status_only_ends, i_clk, i_rst_n, o_out.valid && !o_out.has_byte, o_out.end_of_string)
    `UPC_ASSERT_NXT(a_idle_after_last, i_clk, i_rst_n, in_fire && i_in.in_last, r_phase == ESC_NONE && r_err == ST_OK)

endmodule
